/* sv/rscd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rscd_pkg;

    localparam int REF_DEPTH_DEF = 65536;
    localparam int MAX_RUN_DEF   = 64;

    localparam int KIND_W    = 2;
    localparam int LOAD_AW   = 16;
    localparam int CHAR_W    = 8;
    localparam int DELTA_W   = 18;
    localparam int LEN_W     = 7;
    localparam int SIZE_W    = 17;
    // Wide enough for last_end + delta + length without overflow.
    localparam int CALC_W    = 20;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd2;

    localparam logic signed [DELTA_W-1:0] LAST_END_NONE = -18'sd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } result_t;

endpackage

`default_nettype wire

/* sv/rscd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/reference_segment_copy_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_ready   kind, load_address, char_value, delta, match_length
// output    out_valid / out_ready out_char, last, range_error
// config    cfg_we                cfg_wdata (reference size)
//
// A load or a literal is handled in ST_IDLE alone. A match passes ST_CHECK, then ST_COPY,
// which reads one character per cycle while the output has room, paced by the single read
// port of the reference memory; a range error or an empty copy ends at ST_CHECK.
// The reference memory is not cleared at reset; last_end resets to minus one and
// the reference size to zero, and the block accepts beats from the first cycle after
// reset. A two-entry output buffer holds results while out_ready is low; reads stop
// only when that buffer and the read in flight would overfill it.

module reference_segment_copy_decoder #(
    parameter int REF_DEPTH = rscd_pkg::REF_DEPTH_DEF,
    parameter int MAX_RUN   = rscd_pkg::MAX_RUN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_we,
    input  wire logic        [rscd_pkg::SIZE_W-1:0]  cfg_wdata,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [rscd_pkg::KIND_W-1:0]  kind,
    input  wire logic        [rscd_pkg::LOAD_AW-1:0] load_address,
    input  wire logic        [rscd_pkg::CHAR_W-1:0]  char_value,
    input  wire logic signed [rscd_pkg::DELTA_W-1:0] delta,
    input  wire logic        [rscd_pkg::LEN_W-1:0]   match_length,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [rscd_pkg::CHAR_W-1:0]  out_char,
    output logic                                     last,
    output logic                                     range_error
);

    import rscd_pkg::*;

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;

    state_t                     state_reg, state_next;
    logic [SIZE_W-1:0]          store_size_reg;
    logic signed [DELTA_W-1:0]  last_end_reg, last_end_next;

    logic signed [CALC_W-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [SIZE_W-1:0]          cur_reg, cur_next;
    logic [SIZE_W-1:0]          end_reg, end_next;

    // Result stage between the memory read and the output buffer.
    logic                       p_valid_reg, p_valid_next;
    logic                       p_ram_reg, p_ram_next;
    result_t                    p_data_reg, p_data_next;

    logic                       out_valid_reg, out_valid_next;
    result_t                    out_data_reg, out_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    result_t                    skid_data_reg, skid_data_next;

    logic                       ram_we;
    logic                       ram_re;
    logic [CHAR_W-1:0]          ram_rdata;

    logic [SIZE_W-1:0]          size_eff;
    logic signed [CALC_W-1:0]   size_s;
    logic signed [CALC_W-1:0]   len_s;
    logic signed [CALC_W-1:0]   seg_end;
    logic signed [CALC_W-1:0]   from_s;
    logic signed [CALC_W-1:0]   to_raw;
    logic signed [CALC_W-1:0]   to_s;
    logic                       chk_err;
    logic                       chk_empty;
    logic [SIZE_W-1:0]          cur_inc;
    logic                       cur_last;
    logic [LEN_W-1:0]           len_sat;
    logic                       load_in_range;
    logic                       pop;
    logic [1:0]                 occ_after_pop;
    logic                       room;
    result_t                    push_data;

    // Reference memory.
    rscd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (REF_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(load_address)),
        .wdata (char_value),
        .re    (ram_re),
        .raddr (AW'(cur_reg)),
        .rdata (ram_rdata)
    );

    assign size_eff = (32'(store_size_reg) < 32'(REF_DEPTH)) ? store_size_reg
                                                            : SIZE_W'(REF_DEPTH);
    assign size_s   = $signed({{(CALC_W-SIZE_W){1'b0}}, size_eff});
    assign len_s    = $signed({{(CALC_W-LEN_W){1'b0}}, len_reg});

    assign seg_end  = start_reg + len_s;
    assign chk_err  = (last_end_reg != LAST_END_NONE) &&
                      ((start_reg < 0) || (seg_end > size_s));
    assign from_s   = (start_reg < 0) ? '0 : start_reg;
    assign to_raw   = from_s + len_s;
    assign to_s     = (to_raw > size_s) ? size_s : to_raw;
    assign chk_empty = (from_s >= to_s);

    assign cur_inc  = cur_reg + SIZE_W'(1);
    assign cur_last = (cur_inc == end_reg);

    assign len_sat  = (match_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : match_length;
    assign load_in_range = (32'(load_address) < 32'(REF_DEPTH));

    // Credit check: everything in the result stage and the buffer fits in two slots.
    assign pop           = out_valid_reg && out_ready;
    assign occ_after_pop = 2'({1'b0, out_valid_reg} + {1'b0, skid_valid_reg}
                              + {1'b0, p_valid_reg} - {1'b0, pop});
    assign room          = (occ_after_pop < 2'd2);

    always_comb
    begin
        state_next    = state_reg;
        last_end_next = last_end_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        cur_next      = cur_reg;
        end_next      = end_reg;
        p_valid_next  = 1'b0;
        p_ram_next    = 1'b0;
        p_data_next   = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        in_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = room;
                if (in_valid && room)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            ram_we = load_in_range;
                        end
                        KIND_LITERAL:
                        begin
                            p_valid_next     = 1'b1;
                            p_data_next.ch   = char_value;
                            p_data_next.last = 1'b1;
                        end
                        KIND_MATCH:
                        begin
                            start_next = CALC_W'(last_end_reg) + CALC_W'(delta);
                            len_next   = len_sat;
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (chk_err)
                begin
                    p_valid_next     = 1'b1;
                    p_data_next.last = 1'b1;
                    p_data_next.err  = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    last_end_next = DELTA_W'(seg_end - CALC_W'(1));
                    cur_next      = SIZE_W'(from_s);
                    end_next      = SIZE_W'(to_s);
                    state_next    = chk_empty ? ST_IDLE : ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (room)
                begin
                    ram_re           = 1'b1;
                    p_valid_next     = 1'b1;
                    p_ram_next       = 1'b1;
                    p_data_next.last = cur_last;
                    cur_next         = cur_inc;
                    if (cur_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_data = p_data_reg;
        if (p_ram_reg)
        begin
            push_data.ch = ram_rdata;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (p_valid_reg)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            store_size_reg <= '0;
            last_end_reg   <= LAST_END_NONE;
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_end_reg   <= last_end_next;
            p_valid_reg    <= p_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_we)
            begin
                store_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        len_reg       <= len_next;
        cur_reg       <= cur_next;
        end_reg       <= end_next;
        p_ram_reg     <= p_ram_next;
        p_data_reg    <= p_data_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_data_reg.ch;
    assign last        = out_data_reg.last;
    assign range_error = out_data_reg.err;

    // The result stage and the output buffer never hold more than two beats.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({out_valid_reg, skid_valid_reg, p_valid_reg}) <= 2)
        else $error("output buffer overfilled");

    // The skid entry is only used behind a full output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // While copying, the read pointer stays inside the segment.
    a_copy_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY) |-> (cur_reg < end_reg))
        else $error("copy pointer past segment end");

    // A rejected segment leaves last_end untouched.
    a_err_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CHECK) && chk_err) |=> $stable(last_end_reg))
        else $error("range error changed last_end");

    // Every memory read turns into exactly one result-stage entry in the next cycle.
    a_read_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (p_valid_reg && p_ram_reg))
        else $error("memory read lost");

endmodule

`default_nettype wire

/* tb/segment_copy_checker.sv */
`timescale 1ns / 1ps

module segment_copy_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rscd_pkg::SIZE_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [rscd_pkg::KIND_W-1:0]         kind,
    input  logic [rscd_pkg::LOAD_AW-1:0]        load_address,
    input  logic [rscd_pkg::CHAR_W-1:0]         char_value,
    input  logic signed [rscd_pkg::DELTA_W-1:0] delta,
    input  logic [rscd_pkg::LEN_W-1:0]          match_length,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [rscd_pkg::CHAR_W-1:0]         out_char,
    input  logic                                last,
    input  logic                                range_error,
    output int                                  fail_count,
    output int                                  pending
);

    import rscd_pkg::*;

    logic [CHAR_W-1:0]         ref_copy [REF_DEPTH_DEF];
    logic signed [DELTA_W-1:0] seg_end;
    logic [SIZE_W-1:0]         size_limit;
    result_t                   expected_chars [$];
    result_t                   oldest;

    task automatic queue_result(input result_t r);
        expected_chars.insert(expected_chars.size(), r);
    endtask

    task automatic predict_segment(input logic [KIND_W-1:0]         k,
                                   input logic [LOAD_AW-1:0]        addr,
                                   input logic [CHAR_W-1:0]         ch,
                                   input logic signed [DELTA_W-1:0] d,
                                   input logic [LEN_W-1:0]          len);
        int      size_now;
        int      run;
        int      start;
        int      from;
        int      to;
        int      new_end;
        result_t r;
        size_now = int'(size_limit);
        if (size_now > REF_DEPTH_DEF)
            size_now = REF_DEPTH_DEF;
        case (k)
            KIND_LOAD:
                ref_copy[addr] = ch;
            KIND_LITERAL:
            begin
                r.ch   = ch;
                r.last = 1'b1;
                r.err  = 1'b0;
                queue_result(r);
            end
            KIND_MATCH:
            begin
                run   = (len > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(len);
                start = int'(seg_end) + int'(d);
                // The very first match, or one after the end returned to minus one,
                // is never range checked.
                if (seg_end != LAST_END_NONE && (start < 0 || start + run > size_now))
                begin
                    r.ch   = '0;
                    r.last = 1'b1;
                    r.err  = 1'b1;
                    queue_result(r);
                end
                else
                begin
                    from = (start < 0) ? 0 : start;
                    to   = from + run;
                    if (to > size_now)
                        to = size_now;
                    for (int a = from; a < to; a++)
                    begin
                        r.ch   = ref_copy[a];
                        r.last = (a == to - 1);
                        r.err  = 1'b0;
                        queue_result(r);
                    end
                    new_end = start + run - 1;
                    seg_end = new_end[DELTA_W-1:0];
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                               input logic [CHAR_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_end    = LAST_END_NONE;
            size_limit = '0;
            fail_count = 0;
            expected_chars.delete();
            pending    = 0;
        end
        else
        begin
            // Compare before predicting, so a beat taken at this edge cannot
            // satisfy a result that left at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result expected none actual char %0h last %0b error %0b",
                             $time, out_char, last, range_error);
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    check_field("out_char", oldest.ch, out_char);
                    check_field("last", CHAR_W'(oldest.last), CHAR_W'(last));
                    check_field("range_error", CHAR_W'(oldest.err), CHAR_W'(range_error));
                end
            end
            if (in_valid && in_ready)
                predict_segment(kind, load_address, char_value, delta, match_length);
            if (cfg_we)
                size_limit = cfg_wdata;
            pending = expected_chars.size();
        end
    end

endmodule

/* tb/tb_reference_segment_copy_decoder.sv */
`timescale 1ns / 1ps

module tb_reference_segment_copy_decoder;
    import rscd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int LOW_SPAN         = 32;
    localparam int HIGH_SPAN        = 64;
    localparam int HIGH_BASE        = REF_DEPTH_DEF - HIGH_SPAN;
    localparam int DRAIN_CYCLES     = 80;
    localparam int LONG_STALL       = 400;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PER_PHASE = 12;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_we       = 1'b0;
    logic [SIZE_W-1:0]         cfg_wdata    = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic [KIND_W-1:0]         kind         = KIND_LOAD;
    logic [LOAD_AW-1:0]        load_address = '0;
    logic [CHAR_W-1:0]         char_value   = '0;
    logic signed [DELTA_W-1:0] delta        = '0;
    logic [LEN_W-1:0]          match_length = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic [CHAR_W-1:0]         out_char;
    logic                      last;
    logic                      range_error;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int tx_quiet    = 0;
    int rx_idle_pct = 0;
    int rx_quiet    = 0;
    int stall_req   = 0;
    int stall_ack   = 0;
    int stall_left  = 0;
    int cycle_count = 0;

    // Stimulus-side view of the store and the segment end, used only to keep
    // every copy inside entries that have been loaded.
    bit                        loaded [REF_DEPTH_DEF];
    logic signed [DELTA_W-1:0] plan_end  = LAST_END_NONE;
    int                        plan_size = 0;

    reference_segment_copy_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .load_address (load_address),
        .char_value   (char_value),
        .delta        (delta),
        .match_length (match_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .last         (last),
        .range_error  (range_error)
    );

    segment_copy_checker char_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .load_address (load_address),
        .char_value   (char_value),
        .delta        (delta),
        .match_length (match_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .last         (last),
        .range_error  (range_error),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random back-pressure, quiet stretches, and one long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_req != stall_ack)
        begin
            out_ready  <= 1'b0;
            stall_ack  <= stall_req;
            stall_left <= LONG_STALL;
        end
        else if (rx_quiet > 0)
        begin
            out_ready <= 1'b1;
            rx_quiet  <= rx_quiet - 1;
        end
        else
        begin
            if ($urandom_range(0, 99) < 5)
                rx_quiet <= $urandom_range(10, 30);
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0]         k,
                             input logic [LOAD_AW-1:0]        addr,
                             input logic [CHAR_W-1:0]         ch,
                             input logic signed [DELTA_W-1:0] d,
                             input logic [LEN_W-1:0]          len);
        if (tx_quiet > 0)
            tx_quiet--;
        else if ($urandom_range(0, 99) < 6)
            tx_quiet = $urandom_range(8, 24);
        else if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        load_address <= addr;
        char_value   <= ch;
        delta        <= d;
        match_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_unused();
        send_beat(KIND_UNUSED, LOAD_AW'($urandom), CHAR_W'($urandom),
                  DELTA_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic send_load(input logic [LOAD_AW-1:0] addr, input logic [CHAR_W-1:0] ch);
        loaded[addr] = 1'b1;
        send_beat(KIND_LOAD, addr, ch, DELTA_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic send_literal(input logic [CHAR_W-1:0] ch);
        send_beat(KIND_LITERAL, LOAD_AW'($urandom), ch, DELTA_W'($urandom),
                  LEN_W'($urandom));
    endtask

    // A match that would copy an entry never loaded goes out as a literal instead.
    task automatic send_match_delta(input logic signed [DELTA_W-1:0] d,
                                    input logic [LEN_W-1:0]          len);
        int run;
        int start;
        int from;
        int to;
        int new_end;
        bit rejected;
        bit safe;
        run      = (len > MAX_RUN_DEF) ? MAX_RUN_DEF : int'(len);
        start    = int'(plan_end) + int'(d);
        rejected = (plan_end != LAST_END_NONE) && (start < 0 || start + run > plan_size);
        safe     = 1'b1;
        if (!rejected)
        begin
            from = (start < 0) ? 0 : start;
            to   = from + run;
            if (to > plan_size)
                to = plan_size;
            for (int a = from; a < to; a++)
                if (!loaded[a])
                    safe = 1'b0;
        end
        if (!safe)
            send_literal(CHAR_W'($urandom));
        else
        begin
            send_beat(KIND_MATCH, LOAD_AW'($urandom), CHAR_W'($urandom), d, len);
            if (!rejected)
            begin
                new_end  = start + run - 1;
                plan_end = new_end[DELTA_W-1:0];
            end
        end
    endtask

    task automatic send_match(input int target, input logic [LEN_W-1:0] len);
        int offset;
        offset = target - int'(plan_end);
        send_match_delta(offset[DELTA_W-1:0], len);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // A match with nothing to copy may still be in flight after the last result.
    task automatic set_store_size(input int value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[SIZE_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        plan_size = (value > REF_DEPTH_DEF) ? REF_DEPTH_DEF : value;
    endtask

    task automatic random_beat(output bit counted);
        int pick;
        int len;
        int run;
        int lo;
        int hi;
        int start;
        counted = 1'b1;
        pick    = $urandom_range(0, 99);
        if (pick < 15)
        begin
            if ($urandom_range(0, 2) == 0)
                send_load(LOAD_AW'($urandom), CHAR_W'($urandom));
            else if ($urandom_range(0, 1) == 0)
                send_load(LOAD_AW'($urandom_range(0, LOW_SPAN - 1)), CHAR_W'($urandom));
            else
                send_load(LOAD_AW'($urandom_range(HIGH_BASE, REF_DEPTH_DEF - 1)),
                          CHAR_W'($urandom));
        end
        else if (pick < 35)
            send_literal(CHAR_W'($urandom));
        else if (pick < 39)
        begin
            counted = 1'b0;
            send_unused();
        end
        else
        begin
            len = $urandom_range(1, MAX_RUN_DEF);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(MAX_RUN_DEF + 1, 127);
            else if ($urandom_range(0, 15) == 0)
                len = 0;
            run = (len > MAX_RUN_DEF) ? MAX_RUN_DEF : len;
            if (pick < 86)
            begin
                lo = 0;
                hi = (plan_size < LOW_SPAN) ? plan_size : LOW_SPAN;
                if (plan_size >= REF_DEPTH_DEF && $urandom_range(0, 1) == 1)
                begin
                    lo = HIGH_BASE;
                    hi = REF_DEPTH_DEF;
                end
                if (run > hi - lo)
                begin
                    run = hi - lo;
                    len = run;
                end
                // A zero-length copy at address zero brings the end back to minus one.
                if (len == 0 && $urandom_range(0, 1) == 1)
                    start = 0;
                else
                    start = lo + int'($urandom_range(0, hi - lo - run));
            end
            else if ($urandom_range(0, 1) == 0)
                start = 0 - int'($urandom_range(1, 300));
            else
                start = plan_size - run + int'($urandom_range(1, 300));
            send_match(start, len[LEN_W-1:0]);
        end
    endtask

    task automatic random_run(input int count);
        bit counted;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            random_beat(counted);
            sent += counted;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 18;
        rx_idle_pct <= 68;
        set_store_size(0);

        // Empty reference: literals, an ignored kind, and the unchecked first match.
        send_literal(8'h00);
        send_literal(8'hFF);
        send_unused();
        send_match_delta(18'sd0, 7'd5);
        send_match_delta(18'sd0, 7'd1);
        send_match_delta(-18'sd3, 7'd0);
        // Unchecked again; the new end wraps past the top of the 18-bit range.
        send_match_delta(18'sh1FFFF, 7'd127);
        send_match_delta(18'sh20000, 7'd64);

        for (int a = 0; a < LOW_SPAN; a++)
            send_load(LOAD_AW'(a), CHAR_W'($urandom));
        for (int a = HIGH_BASE; a < REF_DEPTH_DEF; a++)
            send_load(LOAD_AW'(a), CHAR_W'($urandom));

        // Above the store depth; the block clamps it.
        set_store_size(131071);
        send_match(0, 7'd1);
        send_match(HIGH_BASE, 7'd65);
        send_match(REF_DEPTH_DEF - MAX_RUN_DEF, 7'd64);
        send_match(REF_DEPTH_DEF - MAX_RUN_DEF + 1, 7'd64);
        send_match(-1, 7'd1);
        send_match_delta(18'sd65536, 7'd1);
        send_match_delta(-18'sd65536, 7'd3);
        send_match(REF_DEPTH_DEF - 1, 7'd1);
        send_match(10, 7'd0);
        send_literal(CHAR_W'($urandom));

        set_store_size(REF_DEPTH_DEF);
        random_run(RANDOM_PER_PHASE);

        tx_idle_pct = 68;
        rx_idle_pct <= 18;
        set_store_size(100);
        random_run(RANDOM_PER_PHASE / 2);
        wait_drained();
        random_run(RANDOM_PER_PHASE / 2);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        set_store_size(LOW_SPAN);
        stall_req <= stall_req + 1;
        random_run(RANDOM_PER_PHASE);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
